// ===== rtl/core/cldp_pkg.sv =====
// Shared types and constants of the cEMI link-data frame parser.
// No dependencies; imported by cldp_result_queue and cemi_ldata_frame_parser.
package cldp_pkg;

  // Frame status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;
  localparam logic [1:0] STATUS_EXTENDED = 2'd3;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Byte position counter
  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
  localparam logic [POS_W-1:0] POS_XINFO_LEN = 10'd1;

  // Offsets of the header fields relative to the start of the link header
  localparam logic [POS_W-1:0] OFS_CTRL1  = 10'd0;
  localparam logic [POS_W-1:0] OFS_CTRL2  = 10'd1;
  localparam logic [POS_W-1:0] OFS_SRC_HI = 10'd2;
  localparam logic [POS_W-1:0] OFS_SRC_LO = 10'd3;
  localparam logic [POS_W-1:0] OFS_DST_HI = 10'd4;
  localparam logic [POS_W-1:0] OFS_DST_LO = 10'd5;
  localparam logic [POS_W-1:0] OFS_LENGTH = 10'd6;

  // Control field masks
  localparam logic [7:0] CTRL1_STD_FRAME  = 8'h80;
  localparam logic [7:0] CTRL1_NOT_REPEAT = 8'h20;
  localparam logic [7:0] CTRL2_EXT_FORMAT = 8'h0f;

  // Result queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic [1:0]  priority_res;
    logic [2:0]  hop_count;
    logic        group_flag;
    logic        repeat_flag;
    logic [8:0]  payload_count;
    logic        run_end;
  } cldp_result_t;

endpackage

// ===== rtl/core/cldp_result_queue.sv =====
// Small result queue: takes up to two results per cycle when room_two_o is set, hands out one while not stalled.
// Depends on cldp_pkg for the result type and queue geometry.
module cldp_result_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            push_n_i,
  input  cldp_pkg::cldp_result_t push0_i,
  input  cldp_pkg::cldp_result_t push1_i,
  output logic                  room_two_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cldp_pkg::cldp_result_t head_o
);
  import cldp_pkg::*;

  cldp_result_t      mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              pop;
  logic [QPTR_W-1:0] wr_ptr_next;

  assign out_valid_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_two_o  = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign wr_ptr_next = wr_ptr_q + QPTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_n_i);
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_n_i) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_next] <= push1_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> room_two_o)
    else $error("push into queue without room");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i == 2'd0 && !pop) |=> $stable(count_q))
    else $error("queue count moved without push or pop");

endmodule

// ===== rtl/core/cemi_ldata_frame_parser.sv =====
// Top level of the cEMI link-data frame parser.
// Depends on cldp_pkg and cldp_result_queue.

// The parser takes one frame byte per cycle and updates its header capture
// registers in the same cycle the byte is accepted; results (payload bytes
// and the frame summary) land in a four-entry result queue and are shown on
// the output from its registered head. A final payload byte produces two
// results, payload first and summary second; while it is not stalled, the
// output side drains one result per cycle as the input keeps running. The input
// is stalled only while fewer than two queue entries are free, so with the
// output side never stalled the block sustains one byte per cycle. After
// the final byte of a frame the parser is back in its reset state and the
// next frame may follow in the next cycle.
module cemi_ldata_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        end_of_frame_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  frame_status_o,
  output logic [15:0] source_address_o,
  output logic [15:0] dest_address_o,
  output logic [1:0]  priority_res_o,
  output logic [2:0]  hop_count_o,
  output logic        group_flag_o,
  output logic        repeat_flag_o,
  output logic [8:0]  payload_count_o,
  output logic        run_end_o
);
  import cldp_pkg::*;

  // Parser state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       xinfo_q, xinfo_d;
  logic [7:0]       ctrl1_q, ctrl1_d;
  logic [7:0]       ctrl2_q, ctrl2_d;
  logic [15:0]      src_q, src_d;
  logic [15:0]      dst_q, dst_d;
  logic [7:0]       len_q, len_d;

  logic             room_two;
  logic             in_accept;
  logic [POS_W-1:0] hdr_start;
  logic             in_header;
  logic [POS_W-1:0] rel;
  logic             payload_hit;
  logic [POS_W:0]   frame_len;
  logic [POS_W:0]   start_ext;
  logic             too_short;
  logic             mismatch;
  logic             extended;
  logic [1:0]       status;
  logic [1:0]       push_n;
  cldp_result_t     payload_res;
  cldp_result_t     summary_res;
  cldp_result_t     push0;
  cldp_result_t     head;

  // Stall only on queue space, never on valid.
  assign in_stall_o = !room_two;
  assign in_accept  = in_valid_i && room_two;

  // The link header starts after message code, info length and info block.
  assign hdr_start   = POS_W'({2'b00, xinfo_q}) + POS_W'(2);
  assign in_header   = (pos_q >= hdr_start);
  assign rel         = pos_q - hdr_start;
  assign payload_hit = in_header && (rel > OFS_LENGTH);

  // Capture header fields from the current byte.
  always_comb begin
    xinfo_d = xinfo_q;
    ctrl1_d = ctrl1_q;
    ctrl2_d = ctrl2_q;
    src_d   = src_q;
    dst_d   = dst_q;
    len_d   = len_q;
    if (pos_q == POS_XINFO_LEN) begin
      xinfo_d = frame_byte_i;
    end else if (in_header) begin
      case (rel)
        OFS_CTRL1:  ctrl1_d = frame_byte_i;
        OFS_CTRL2:  ctrl2_d = frame_byte_i;
        OFS_SRC_HI: src_d   = {frame_byte_i, src_q[7:0]};
        OFS_SRC_LO: src_d   = {src_q[15:8], frame_byte_i};
        OFS_DST_HI: dst_d   = {frame_byte_i, dst_q[7:0]};
        OFS_DST_LO: dst_d   = {dst_q[15:8], frame_byte_i};
        OFS_LENGTH: len_d   = frame_byte_i;
        default: ;
      endcase
    end
  end

  // Frame checks, using the header start as it stood before this byte.
  assign frame_len = {1'b0, pos_q} + (POS_W+1)'(1);
  assign start_ext = {1'b0, hdr_start};
  assign too_short = frame_len < start_ext + (POS_W+1)'(7);
  assign mismatch  = frame_len != start_ext + (POS_W+1)'(8) + (POS_W+1)'(len_d);
  assign extended  = ((ctrl1_d & CTRL1_STD_FRAME) == 8'h00)
                  && ((ctrl2_d & CTRL2_EXT_FORMAT) != 8'h00);

  always_comb begin
    if (too_short) begin
      status = STATUS_SHORT;
    end else if (mismatch) begin
      status = STATUS_MISMATCH;
    end else if (extended) begin
      status = STATUS_EXTENDED;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    payload_res              = '0;
    payload_res.result_kind  = KIND_PAYLOAD;
    payload_res.payload_byte = frame_byte_i;
    payload_res.run_end      = !end_of_frame_i;

    summary_res                = '0;
    summary_res.result_kind    = KIND_SUMMARY;
    summary_res.frame_status   = status;
    summary_res.source_address = src_d;
    summary_res.dest_address   = dst_d;
    summary_res.priority_res   = ctrl1_d[3:2];
    summary_res.hop_count      = ctrl2_d[6:4];
    summary_res.group_flag     = ctrl2_d[7];
    summary_res.repeat_flag    = ((ctrl1_d & CTRL1_NOT_REPEAT) == 8'h00);
    summary_res.payload_count  = too_short ? 9'd0 : {1'b0, len_d} + 9'd1;
    summary_res.run_end        = 1'b1;

    push0  = payload_hit ? payload_res : summary_res;
    push_n = in_accept ? 2'({1'b0, payload_hit}) + 2'({1'b0, end_of_frame_i}) : 2'd0;
  end

  // Advance the byte position; saturate on very long frames.
  always_comb begin
    pos_d = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : POS_MAX;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      xinfo_q <= '0;
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      len_q   <= '0;
    end else if (in_accept) begin
      if (end_of_frame_i) begin
        // drop all captures, ready for the next frame
        pos_q   <= '0;
        xinfo_q <= '0;
        ctrl1_q <= '0;
        ctrl2_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        len_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        xinfo_q <= xinfo_d;
        ctrl1_q <= ctrl1_d;
        ctrl2_q <= ctrl2_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        len_q   <= len_d;
      end
    end
  end

  cldp_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push0_i     (push0),
    .push1_i     (summary_res),
    .room_two_o  (room_two),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign result_kind_o    = head.result_kind;
  assign payload_byte_o   = head.payload_byte;
  assign frame_status_o   = head.frame_status;
  assign source_address_o = head.source_address;
  assign dest_address_o   = head.dest_address;
  assign priority_res_o   = head.priority_res;
  assign hop_count_o      = head.hop_count;
  assign group_flag_o     = head.group_flag;
  assign repeat_flag_o    = head.repeat_flag;
  assign payload_count_o  = head.payload_count;
  assign run_end_o        = head.run_end;

  a_summary_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_SUMMARY) |-> run_end_o)
    else $error("summary without run end");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_PAYLOAD)
      |-> (frame_status_o == STATUS_OK && payload_count_o == 9'd0))
    else $error("payload result carries summary fields");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_of_frame_i) |=> (pos_q == '0 && xinfo_q == 8'h00))
    else $error("parser not reset after frame end");

endmodule
